[design/tre_pkg.sv]
// Shared types, widths and opcode codes of the two-register machine execute unit.
// No dependencies.
`default_nettype none
package tre_pkg;

   localparam int DATA_WIDTH  = 32;
   localparam int SHIFT_WIDTH = $clog2(DATA_WIDTH);
   localparam int COUNT_WIDTH = $clog2(DATA_WIDTH + 1);
   localparam int KIND_WIDTH  = 7;
   localparam int CSR_WIDTH   = 8;

   localparam logic [KIND_WIDTH-1:0] OP_ICX  = 7'd1;
   localparam logic [KIND_WIDTH-1:0] OP_ICY  = 7'd2;
   localparam logic [KIND_WIDTH-1:0] OP_ADX  = 7'd3;
   localparam logic [KIND_WIDTH-1:0] OP_ADY  = 7'd4;
   localparam logic [KIND_WIDTH-1:0] OP_SUX  = 7'd5;
   localparam logic [KIND_WIDTH-1:0] OP_SUY  = 7'd6;
   localparam logic [KIND_WIDTH-1:0] OP_MUX  = 7'd7;
   localparam logic [KIND_WIDTH-1:0] OP_MUY  = 7'd8;
   localparam logic [KIND_WIDTH-1:0] OP_DIX  = 7'd9;
   localparam logic [KIND_WIDTH-1:0] OP_DIY  = 7'd10;
   localparam logic [KIND_WIDTH-1:0] OP_MOX  = 7'd11;
   localparam logic [KIND_WIDTH-1:0] OP_MOY  = 7'd12;
   localparam logic [KIND_WIDTH-1:0] OP_TVF  = 7'd13;
   localparam logic [KIND_WIDTH-1:0] OP_TVX  = 7'd15;
   localparam logic [KIND_WIDTH-1:0] OP_TVY  = 7'd16;
   localparam logic [KIND_WIDTH-1:0] OP_PPX  = 7'd17;
   localparam logic [KIND_WIDTH-1:0] OP_PPY  = 7'd18;
   localparam logic [KIND_WIDTH-1:0] OP_MPX  = 7'd19;
   localparam logic [KIND_WIDTH-1:0] OP_MPY  = 7'd20;
   localparam logic [KIND_WIDTH-1:0] OP_DMX  = 7'd21;
   localparam logic [KIND_WIDTH-1:0] OP_DMY  = 7'd22;
   localparam logic [KIND_WIDTH-1:0] OP_DPX  = 7'd23;
   localparam logic [KIND_WIDTH-1:0] OP_DPY  = 7'd24;
   localparam logic [KIND_WIDTH-1:0] OP_XVY  = 7'd25;
   localparam logic [KIND_WIDTH-1:0] OP_YVX  = 7'd26;
   localparam logic [KIND_WIDTH-1:0] OP_XVT  = 7'd27;
   localparam logic [KIND_WIDTH-1:0] OP_YVT  = 7'd28;
   localparam logic [KIND_WIDTH-1:0] OP_XVF  = 7'd29;
   localparam logic [KIND_WIDTH-1:0] OP_YVF  = 7'd30;
   localparam logic [KIND_WIDTH-1:0] OP_MVX  = 7'd31;
   localparam logic [KIND_WIDTH-1:0] OP_MVY  = 7'd32;
   localparam logic [KIND_WIDTH-1:0] OP_RDM  = 7'd33;
   localparam logic [KIND_WIDTH-1:0] OP_ANX  = 7'd36;
   localparam logic [KIND_WIDTH-1:0] OP_ANY  = 7'd37;
   localparam logic [KIND_WIDTH-1:0] OP_ORX  = 7'd38;
   localparam logic [KIND_WIDTH-1:0] OP_ORY  = 7'd39;
   localparam logic [KIND_WIDTH-1:0] OP_XOX  = 7'd40;
   localparam logic [KIND_WIDTH-1:0] OP_XOY  = 7'd41;
   localparam logic [KIND_WIDTH-1:0] OP_LSX  = 7'd42;
   localparam logic [KIND_WIDTH-1:0] OP_LSY  = 7'd43;
   localparam logic [KIND_WIDTH-1:0] OP_RSX  = 7'd44;
   localparam logic [KIND_WIDTH-1:0] OP_RSY  = 7'd45;
   localparam logic [KIND_WIDTH-1:0] OP_EQX  = 7'd46;
   localparam logic [KIND_WIDTH-1:0] OP_EQY  = 7'd47;
   localparam logic [KIND_WIDTH-1:0] OP_NQX  = 7'd48;
   localparam logic [KIND_WIDTH-1:0] OP_NQY  = 7'd49;
   localparam logic [KIND_WIDTH-1:0] OP_SPX  = 7'd50;
   localparam logic [KIND_WIDTH-1:0] OP_SPY  = 7'd51;
   localparam logic [KIND_WIDTH-1:0] OP_INX  = 7'd52;
   localparam logic [KIND_WIDTH-1:0] OP_INY  = 7'd53;
   localparam logic [KIND_WIDTH-1:0] OP_IEX  = 7'd54;
   localparam logic [KIND_WIDTH-1:0] OP_IEY  = 7'd55;
   localparam logic [KIND_WIDTH-1:0] OP_SEX  = 7'd56;
   localparam logic [KIND_WIDTH-1:0] OP_SEY  = 7'd57;
   localparam logic [KIND_WIDTH-1:0] OP_NOX  = 7'd58;
   localparam logic [KIND_WIDTH-1:0] OP_NOY  = 7'd59;
   localparam logic [KIND_WIDTH-1:0] OP_CNE  = 7'd60;
   localparam logic [KIND_WIDTH-1:0] OP_HALT = 7'd61;
   localparam logic [KIND_WIDTH-1:0] OP_XPP  = 7'd62;
   localparam logic [KIND_WIDTH-1:0] OP_YPP  = 7'd63;
   localparam logic [KIND_WIDTH-1:0] OP_SWX  = 7'd64;
   localparam logic [KIND_WIDTH-1:0] OP_SWY  = 7'd65;
   localparam logic [KIND_WIDTH-1:0] OP_REX  = 7'd66;
   localparam logic [KIND_WIDTH-1:0] OP_REY  = 7'd67;
   localparam logic [KIND_WIDTH-1:0] OP_XMP  = 7'd68;
   localparam logic [KIND_WIDTH-1:0] OP_YMP  = 7'd69;
   localparam logic [KIND_WIDTH-1:0] OP_STX  = 7'd70;
   localparam logic [KIND_WIDTH-1:0] OP_STY  = 7'd71;
   localparam logic [KIND_WIDTH-1:0] OP_LOG  = 7'd72;
   localparam logic [KIND_WIDTH-1:0] OP_IDN  = 7'd73;

   localparam logic [CSR_WIDTH-1:0] CSR_RAM_ID = 8'd0;
   localparam logic [CSR_WIDTH-1:0] CSR_CPU_ID = 8'd1;

   typedef struct packed {
      logic latch;
      logic div_start;
      logic div_step;
      logic commit;
   } dp_cmd_type;

   typedef struct packed {
      logic div_needed;
      logic div_done;
   } dp_sts_type;

endpackage
`default_nettype wire

[design/tre_ctrl.sv]
// Sequencer of the execute unit: handshakes, divider stepping, result register valid.
// Depends on tre_pkg.
`default_nettype none
module tre_ctrl import tre_pkg::*; (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  wire        rsp_stall,
   input  dp_sts_type sts,
   output dp_cmd_type cmd
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_LOAD   = 4'b0010,
      ST_DIV    = 4'b0100,
      ST_COMMIT = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (sts.div_needed) begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV;
            end else begin
               state_in = ST_COMMIT;
            end
         end
         ST_DIV: begin
            if (sts.div_done) begin
               state_in = ST_COMMIT;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         ST_COMMIT: begin
            // hold until the result register is free
            if (out_free) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

[design/tre_datapath.sv]
// Register file, ALU, multiplier, iterative divider and result register of the unit.
// Depends on tre_pkg.
`default_nettype none
module tre_datapath import tre_pkg::*; (
   input  wire                         clock,
   input  wire                         reset,
   input  dp_cmd_type                  cmd,
   output dp_sts_type                  sts,
   input  wire                         csr_write_enable,
   input  wire  [CSR_WIDTH-1:0]        csr_index,
   input  wire  [CSR_WIDTH-1:0]        csr_write_data,
   input  wire  [KIND_WIDTH-1:0]       req_kind,
   input  wire  signed [DATA_WIDTH-1:0] req_read_data,
   output logic signed [DATA_WIDTH-1:0] rsp_reg_x,
   output logic signed [DATA_WIDTH-1:0] rsp_reg_y,
   output logic signed [DATA_WIDTH-1:0] rsp_reg_temp,
   output logic signed [DATA_WIDTH-1:0] rsp_prog_ptr,
   output logic signed [DATA_WIDTH-1:0] rsp_mem_ptr,
   output logic                         rsp_write_enable,
   output logic signed [DATA_WIDTH-1:0] rsp_write_data,
   output logic                         rsp_char_valid,
   output logic [7:0]                   rsp_char_out,
   output logic [7:0]                   rsp_return_value,
   output logic                         rsp_div_zero
);

   localparam int DW = DATA_WIDTH;
   localparam logic signed [DW-1:0] ONE = DW'(1);

   logic [CSR_WIDTH-1:0]  ram_id_ff, cpu_id_ff;
   logic [KIND_WIDTH-1:0] op_ff;
   logic signed [DW-1:0]  rd_ff;
   logic signed [DW-1:0]  x_ff, y_ff, t_ff, f_ff, pp_ff, mp_ff, dds_ff, pds_ff;
   logic signed [DW-1:0]  x_in, y_in, t_in, f_in, pp_in, mp_in, dds_in, pds_in;
   logic                  we_in, cv_in, dz_in;
   logic signed [DW-1:0]  wd_in;
   logic [7:0]            co_in, rv_in;

   logic [DW-1:0]          rem_ff, quo_ff, md_ff;
   logic                   na_ff, nd_ff;
   logic [COUNT_WIDTH-1:0] cnt_ff;
   logic [DW:0]            trial;
   logic [DW:0]            diff;
   logic                   is_div, div_x, want_rem;
   logic signed [DW-1:0]   dividend;
   logic signed [DW-1:0]   div_result;
   logic signed [2*DW-1:0] prod_x, prod_y;
   logic [SHIFT_WIDTH-1:0] shamt;
   logic                   dmatch, pmatch;

   assign is_div   = (op_ff == OP_DIX) || (op_ff == OP_DIY) ||
                     (op_ff == OP_MOX) || (op_ff == OP_MOY);
   assign div_x    = (op_ff == OP_DIX) || (op_ff == OP_MOX);
   assign want_rem = (op_ff == OP_MOX) || (op_ff == OP_MOY);
   assign dividend = div_x ? x_ff : y_ff;

   assign sts.div_needed = is_div && (t_ff != '0);
   assign sts.div_done   = (cnt_ff == COUNT_WIDTH'(DW));

   // one quotient bit a step on magnitudes
   assign trial = {rem_ff, quo_ff[DW-1]};
   assign diff  = trial - {1'b0, md_ff};

   assign div_result = want_rem ? (na_ff ? -$signed(rem_ff) : $signed(rem_ff))
                                : ((na_ff ^ nd_ff) ? -$signed(quo_ff) : $signed(quo_ff));

   assign prod_x = x_ff * t_ff;
   assign prod_y = y_ff * t_ff;
   assign shamt  = t_ff[SHIFT_WIDTH-1:0];
   assign dmatch = dds_ff == {{(DW-CSR_WIDTH){1'b0}}, ram_id_ff};
   assign pmatch = pds_ff == {{(DW-CSR_WIDTH){1'b0}}, ram_id_ff};

   always_comb begin
      x_in   = x_ff;
      y_in   = y_ff;
      t_in   = t_ff;
      f_in   = f_ff;
      pp_in  = pp_ff;
      mp_in  = mp_ff;
      dds_in = dds_ff;
      pds_in = pds_ff;
      we_in  = 1'b0;
      wd_in  = '0;
      cv_in  = 1'b0;
      co_in  = '0;
      rv_in  = '0;
      dz_in  = 1'b0;
      unique case (op_ff)
         OP_ICX:  x_in = x_ff + ONE;
         OP_ICY:  y_in = y_ff + ONE;
         OP_ADX:  x_in = x_ff + t_ff;
         OP_ADY:  y_in = y_ff + t_ff;
         OP_SUX:  x_in = x_ff - t_ff;
         OP_SUY:  y_in = y_ff - t_ff;
         OP_MUX:  x_in = prod_x[DW-1:0];
         OP_MUY:  y_in = prod_y[DW-1:0];
         OP_DIX, OP_MOX: begin
            if (t_ff == '0) dz_in = 1'b1;
            else            x_in  = div_result;
         end
         OP_DIY, OP_MOY: begin
            if (t_ff == '0) dz_in = 1'b1;
            else            y_in  = div_result;
         end
         OP_TVF:  t_in = f_ff;
         OP_TVX:  t_in = x_ff;
         OP_TVY:  t_in = y_ff;
         OP_PPX:  pp_in = x_ff - ONE;
         OP_PPY:  pp_in = y_ff - ONE;
         OP_MPX:  mp_in = x_ff;
         OP_MPY:  mp_in = y_ff;
         OP_DMX:  dds_in = x_ff;
         OP_DMY:  dds_in = y_ff;
         OP_DPX:  pds_in = x_ff;
         OP_DPY:  pds_in = y_ff;
         OP_XVY:  x_in = y_ff;
         OP_YVX:  y_in = x_ff;
         OP_XVT:  x_in = t_ff;
         OP_YVT:  y_in = t_ff;
         OP_XVF:  x_in = f_ff;
         OP_YVF:  y_in = f_ff;
         OP_MVX: begin
            we_in = dmatch;
            wd_in = dmatch ? x_ff : '0;
         end
         OP_MVY: begin
            we_in = dmatch;
            wd_in = dmatch ? y_ff : '0;
         end
         OP_RDM:  if (dmatch) f_in = rd_ff;
         OP_ANX:  x_in = x_ff & t_ff;
         OP_ANY:  y_in = y_ff & t_ff;
         OP_ORX:  x_in = x_ff | t_ff;
         OP_ORY:  y_in = y_ff | t_ff;
         OP_XOX:  x_in = x_ff ^ t_ff;
         OP_XOY:  y_in = y_ff ^ t_ff;
         OP_LSX:  x_in = x_ff <<< shamt;
         OP_LSY:  y_in = y_ff <<< shamt;
         OP_RSX:  x_in = x_ff >>> shamt;
         OP_RSY:  y_in = y_ff >>> shamt;
         OP_EQX:  x_in = {{(DW-1){1'b0}}, x_ff == t_ff};
         OP_EQY:  y_in = {{(DW-1){1'b0}}, y_ff == t_ff};
         OP_NQX:  x_in = {{(DW-1){1'b0}}, x_ff != t_ff};
         OP_NQY:  y_in = {{(DW-1){1'b0}}, y_ff != t_ff};
         OP_SPX:  x_in = {{(DW-1){1'b0}}, t_ff < x_ff};
         OP_SPY:  y_in = {{(DW-1){1'b0}}, t_ff < y_ff};
         OP_INX:  x_in = {{(DW-1){1'b0}}, x_ff < t_ff};
         OP_INY:  y_in = {{(DW-1){1'b0}}, y_ff < t_ff};
         OP_IEX:  x_in = {{(DW-1){1'b0}}, !(t_ff < x_ff)};
         OP_IEY:  y_in = {{(DW-1){1'b0}}, !(t_ff < y_ff)};
         OP_SEX:  x_in = {{(DW-1){1'b0}}, !(x_ff < t_ff)};
         OP_SEY:  y_in = {{(DW-1){1'b0}}, !(y_ff < t_ff)};
         OP_NOX:  x_in = ~x_ff;
         OP_NOY:  y_in = ~y_ff;
         OP_CNE:  if (t_ff == '0) pp_in = pp_ff + ONE;
         OP_HALT: pp_in = pp_ff - ONE;
         OP_XPP:  x_in = pp_ff;
         OP_YPP:  y_in = pp_ff;
         OP_SWX: begin
            x_in = t_ff;
            t_in = x_ff;
         end
         OP_SWY: begin
            y_in = t_ff;
            t_in = y_ff;
         end
         OP_REX:  x_in = '0;
         OP_REY:  y_in = '0;
         OP_XMP:  x_in = mp_ff;
         OP_YMP:  y_in = mp_ff;
         OP_STX: begin
            pp_in = pp_ff + ONE;
            if (pmatch) x_in = rd_ff;
         end
         OP_STY: begin
            pp_in = pp_ff + ONE;
            if (pmatch) y_in = rd_ff;
         end
         OP_LOG: begin
            cv_in = 1'b1;
            co_in = t_ff[7:0];
         end
         OP_IDN:  rv_in = cpu_id_ff;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ram_id_ff <= '0;
         cpu_id_ff <= '0;
      end else if (csr_write_enable) begin
         if (csr_index == CSR_RAM_ID) ram_id_ff <= csr_write_data;
         if (csr_index == CSR_CPU_ID) cpu_id_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         op_ff <= req_kind;
         rd_ff <= req_read_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.div_start) begin
         cnt_ff <= '0;
      end else if (cmd.div_step) begin
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         rem_ff <= '0;
         quo_ff <= dividend[DW-1] ? -dividend : dividend;
         md_ff  <= t_ff[DW-1] ? -t_ff : t_ff;
         na_ff  <= dividend[DW-1];
         nd_ff  <= t_ff[DW-1];
      end else if (cmd.div_step) begin
         if (!diff[DW]) begin
            rem_ff <= diff[DW-1:0];
            quo_ff <= {quo_ff[DW-2:0], 1'b1};
         end else begin
            rem_ff <= trial[DW-1:0];
            quo_ff <= {quo_ff[DW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff   <= '0;
         y_ff   <= '0;
         t_ff   <= '0;
         f_ff   <= '0;
         pp_ff  <= '0;
         mp_ff  <= '0;
         dds_ff <= '0;
         pds_ff <= '0;
         rsp_reg_x        <= '0;
         rsp_reg_y        <= '0;
         rsp_reg_temp     <= '0;
         rsp_prog_ptr     <= '0;
         rsp_mem_ptr      <= '0;
         rsp_write_enable <= 1'b0;
         rsp_write_data   <= '0;
         rsp_char_valid   <= 1'b0;
         rsp_char_out     <= '0;
         rsp_return_value <= '0;
         rsp_div_zero     <= 1'b0;
      end else if (cmd.commit) begin
         x_ff   <= x_in;
         y_ff   <= y_in;
         t_ff   <= t_in;
         f_ff   <= f_in;
         pp_ff  <= pp_in;
         mp_ff  <= mp_in;
         dds_ff <= dds_in;
         pds_ff <= pds_in;
         rsp_reg_x        <= x_in;
         rsp_reg_y        <= y_in;
         rsp_reg_temp     <= t_in;
         rsp_prog_ptr     <= pp_in;
         rsp_mem_ptr      <= mp_in;
         rsp_write_enable <= we_in;
         rsp_write_data   <= wd_in;
         rsp_char_valid   <= cv_in;
         rsp_char_out     <= co_in;
         rsp_return_value <= rv_in;
         rsp_div_zero     <= dz_in;
      end
   end

endmodule
`default_nettype wire

[design/two_register_machine_execute.sv]
// Top level of the two-register machine execute unit: sequencer plus datapath.
// Depends on tre_pkg, tre_ctrl and tre_datapath.
//
//   channel  direction  handshake               payload
//   req      in         req_valid / req_stall   kind, read_data
//   rsp      out        rsp_valid / rsp_stall   registers, write, char, id, div_zero
//   csr      in         csr_write_enable        csr_index, csr_write_data
//
// A word goes from accept through the load and commit states to the result; divide and modulo with a nonzero
// divisor also pass through the divide state, where the radix-2 divider steps one quotient bit a cycle.
// One word is in flight; the next is accepted while the result still waits.
// Synchronous reset clears all machine registers and the configuration.
// A stalled result holds; the finished word waits until the result register frees.
`default_nettype none
module two_register_machine_execute import tre_pkg::*; (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_stall,
   input  wire  [KIND_WIDTH-1:0]        req_kind,
   input  wire  signed [DATA_WIDTH-1:0] req_read_data,
   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   output logic signed [DATA_WIDTH-1:0] rsp_reg_x,
   output logic signed [DATA_WIDTH-1:0] rsp_reg_y,
   output logic signed [DATA_WIDTH-1:0] rsp_reg_temp,
   output logic signed [DATA_WIDTH-1:0] rsp_prog_ptr,
   output logic signed [DATA_WIDTH-1:0] rsp_mem_ptr,
   output logic                         rsp_write_enable,
   output logic signed [DATA_WIDTH-1:0] rsp_write_data,
   output logic                         rsp_char_valid,
   output logic [7:0]                   rsp_char_out,
   output logic [7:0]                   rsp_return_value,
   output logic                         rsp_div_zero,
   input  wire                          csr_write_enable,
   input  wire  [CSR_WIDTH-1:0]         csr_index,
   input  wire  [CSR_WIDTH-1:0]         csr_write_data
);

   dp_cmd_type cmd;
   dp_sts_type sts;

   tre_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   tre_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_kind         (req_kind),
      .req_read_data    (req_read_data),
      .rsp_reg_x        (rsp_reg_x),
      .rsp_reg_y        (rsp_reg_y),
      .rsp_reg_temp     (rsp_reg_temp),
      .rsp_prog_ptr     (rsp_prog_ptr),
      .rsp_mem_ptr      (rsp_mem_ptr),
      .rsp_write_enable (rsp_write_enable),
      .rsp_write_data   (rsp_write_data),
      .rsp_char_valid   (rsp_char_valid),
      .rsp_char_out     (rsp_char_out),
      .rsp_return_value (rsp_return_value),
      .rsp_div_zero     (rsp_div_zero)
   );

   // busy right after an accept
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("accept did not make the unit busy");

   // no write data without a memory write
   assert property (@(posedge clock) disable iff (reset)
      !rsp_write_enable |-> (rsp_write_data == '0))
      else $error("write data without write enable");

   // divider only steps with no result committed in the same cycle
   assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> !(cmd.div_step || cmd.div_start || cmd.latch))
      else $error("commit overlaps other datapath command");

endmodule
`default_nettype wire

[verif/tb_top.sv]
// Self-checking bench for the two-register machine execute unit: random and directed
// opcode words, a cycle-free predictor kept in a scoreboard class. Depends on tre_pkg.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
   import tre_pkg::*;

   typedef logic signed [DATA_WIDTH-1:0] word_t;

   typedef struct packed {
      word_t      x, y, temp, pp, mp;
      logic       we;
      word_t      wd;
      logic       cv;
      logic [7:0] co;
      logic [7:0] rv;
      logic       dz;
   } machine_result_t;

   localparam logic [KIND_WIDTH-1:0] OP_NUL = 7'd0;
   localparam logic [KIND_WIDTH-1:0] OP_END = 7'd14;
   localparam logic [KIND_WIDTH-1:0] OP_TMX = 7'd34;
   localparam logic [KIND_WIDTH-1:0] OP_TMY = 7'd35;
   localparam word_t MOST_NEG = {1'b1, {(DATA_WIDTH-1){1'b0}}};

   int error_count = 0;

   task automatic report_mismatch(input string what, input word_t got, input word_t want);
      $display("MISMATCH %s: got %h, want %h", what, got, want);
      error_count++;
   endtask

   class machine_scoreboard;
      word_t x, y, temp, fetched, pp, mp, dsel, psel;
      logic [7:0] ram_id, cpu_id;
      machine_result_t pending[$];

      function void clear();
         x = 0; y = 0; temp = 0; fetched = 0; pp = 0; mp = 0; dsel = 0; psel = 0;
         ram_id = 0; cpu_id = 0;
         pending.delete();
      endfunction

      // returns 0 on zero divisor and leaves r unchanged
      function automatic bit divide(ref word_t r, input word_t d, input bit want_rem);
         if (d == 0) return 0;
         if (r == MOST_NEG && d == -1) r = want_rem ? 0 : MOST_NEG;
         else r = want_rem ? r % d : r / d;
         return 1;
      endfunction

      function void note_word(logic [KIND_WIDTH-1:0] k, word_t rd);
         machine_result_t e;
         word_t t, sw;
         logic [4:0] sh;
         bit dm, pm;
         t = temp;
         sh = t[4:0];
         dm = (dsel == word_t'({24'd0, ram_id}));
         pm = (psel == word_t'({24'd0, ram_id}));
         e = '0;
         case (k)
            OP_ICX: x = x + 1;
            OP_ICY: y = y + 1;
            OP_ADX: x = x + t;
            OP_ADY: y = y + t;
            OP_SUX: x = x - t;
            OP_SUY: y = y - t;
            OP_MUX: x = x * t;
            OP_MUY: y = y * t;
            OP_DIX: e.dz = !divide(x, t, 0);
            OP_DIY: e.dz = !divide(y, t, 0);
            OP_MOX: e.dz = !divide(x, t, 1);
            OP_MOY: e.dz = !divide(y, t, 1);
            OP_TVF: temp = fetched;
            OP_TVX: temp = x;
            OP_TVY: temp = y;
            OP_PPX: pp = x - 1;
            OP_PPY: pp = y - 1;
            OP_MPX: mp = x;
            OP_MPY: mp = y;
            OP_DMX: dsel = x;
            OP_DMY: dsel = y;
            OP_DPX: psel = x;
            OP_DPY: psel = y;
            OP_XVY: x = y;
            OP_YVX: y = x;
            OP_XVT: x = t;
            OP_YVT: y = t;
            OP_XVF: x = fetched;
            OP_YVF: y = fetched;
            OP_MVX: if (dm) begin e.we = 1; e.wd = x; end
            OP_MVY: if (dm) begin e.we = 1; e.wd = y; end
            OP_RDM: if (dm) fetched = rd;
            OP_ANX: x = x & t;
            OP_ANY: y = y & t;
            OP_ORX: x = x | t;
            OP_ORY: y = y | t;
            OP_XOX: x = x ^ t;
            OP_XOY: y = y ^ t;
            OP_LSX: x = x << sh;
            OP_LSY: y = y << sh;
            OP_RSX: x = x >>> sh;
            OP_RSY: y = y >>> sh;
            OP_EQX: x = word_t'(x == t);
            OP_EQY: y = word_t'(y == t);
            OP_NQX: x = word_t'(x != t);
            OP_NQY: y = word_t'(y != t);
            OP_SPX: x = word_t'(t < x);
            OP_SPY: y = word_t'(t < y);
            OP_INX: x = word_t'(x < t);
            OP_INY: y = word_t'(y < t);
            OP_IEX: x = word_t'(!(t < x));
            OP_IEY: y = word_t'(!(t < y));
            OP_SEX: x = word_t'(!(x < t));
            OP_SEY: y = word_t'(!(y < t));
            OP_NOX: x = ~x;
            OP_NOY: y = ~y;
            OP_CNE: if (t == 0) pp = pp + 1;
            OP_HALT: pp = pp - 1;
            OP_XPP: x = pp;
            OP_YPP: y = pp;
            OP_SWX: begin sw = x; x = t; temp = sw; end
            OP_SWY: begin sw = y; y = t; temp = sw; end
            OP_REX: x = 0;
            OP_REY: y = 0;
            OP_XMP: x = mp;
            OP_YMP: y = mp;
            OP_STX: begin pp = pp + 1; if (pm) x = rd; end
            OP_STY: begin pp = pp + 1; if (pm) y = rd; end
            OP_LOG: begin e.cv = 1; e.co = t[7:0]; end
            OP_IDN: e.rv = cpu_id;
            default: ;
         endcase
         e.x = x; e.y = y; e.temp = temp; e.pp = pp; e.mp = mp;
         pending.push_back(e);
      endfunction

      task check_word(machine_result_t got);
         machine_result_t w;
         if (pending.size() == 0) begin
            report_mismatch("unexpected word", 0, 0);
            return;
         end
         w = pending.pop_front();
         if (got.x !== w.x) report_mismatch("reg_x", got.x, w.x);
         if (got.y !== w.y) report_mismatch("reg_y", got.y, w.y);
         if (got.temp !== w.temp) report_mismatch("reg_temp", got.temp, w.temp);
         if (got.pp !== w.pp) report_mismatch("prog_ptr", got.pp, w.pp);
         if (got.mp !== w.mp) report_mismatch("mem_ptr", got.mp, w.mp);
         if (got.we !== w.we)
            report_mismatch("write_enable", word_t'(got.we), word_t'(w.we));
         if (got.wd !== w.wd) report_mismatch("write_data", got.wd, w.wd);
         if (got.cv !== w.cv)
            report_mismatch("char_valid", word_t'(got.cv), word_t'(w.cv));
         if (got.co !== w.co)
            report_mismatch("char_out", word_t'(got.co), word_t'(w.co));
         if (got.rv !== w.rv)
            report_mismatch("return_value", word_t'(got.rv), word_t'(w.rv));
         if (got.dz !== w.dz)
            report_mismatch("div_zero", word_t'(got.dz), word_t'(w.dz));
      endtask
   endclass

   logic clock = 0, reset = 1;
   logic req_valid = 0, rsp_stall = 0;
   logic req_stall, rsp_valid;
   logic [KIND_WIDTH-1:0] req_kind = '0;
   word_t req_read_data = '0;
   word_t rsp_reg_x, rsp_reg_y, rsp_reg_temp, rsp_prog_ptr, rsp_mem_ptr, rsp_write_data;
   logic rsp_write_enable, rsp_char_valid, rsp_div_zero;
   logic [7:0] rsp_char_out, rsp_return_value;
   logic csr_write_enable = 0;
   logic [CSR_WIDTH-1:0] csr_index = '0, csr_write_data = '0;

   int send_idle_pct = 0, stall_pct = 0, hold_cycles = 0, quiet_cycles = 0;
   machine_scoreboard sb;

   two_register_machine_execute DUT (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // receiver: random stall, or a long hold-off when asked
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_stall <= 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_word('{rsp_reg_x, rsp_reg_y, rsp_reg_temp, rsp_prog_ptr, rsp_mem_ptr,
                         rsp_write_enable, rsp_write_data, rsp_char_valid, rsp_char_out,
                         rsp_return_value, rsp_div_zero});
   end

   // watchdog: cycles with no word moving on either side
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 20000) begin
         $display("two_register_machine_execute test failed");
         $finish;
      end
   end

   // valid stays up after an accept so back-to-back words need no gap; idle drops it
   task automatic send_word(input logic [KIND_WIDTH-1:0] k, input word_t rd);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_kind <= k;
      req_read_data <= rd;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_word(k, rd);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (sb.pending.size() > 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_WIDTH-1:0] idx, input logic [7:0] v);
      csr_write_enable <= 1;
      csr_index <= idx;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_enable <= 0;
      if (idx == CSR_RAM_ID) sb.ram_id = v; else sb.cpu_id = v;
      @(posedge clock);
   endtask

   function automatic word_t rand_data();
      case ($urandom_range(5))
         0: return word_t'($urandom_range(8));
         1: return -word_t'($urandom_range(8));
         2: return MOST_NEG;
         3: return {1'b0, {(DATA_WIDTH-1){1'b1}}};
         default: return word_t'($urandom);
      endcase
   endfunction

   // random word, biased toward loading temp with edge values and small selectors
   task automatic send_random();
      logic [KIND_WIDTH-1:0] k;
      int r;
      r = $urandom_range(99);
      if (r < 10) begin
         send_word(OP_STX, rand_data());
         send_word(OP_SWX, rand_data());
      end else if (r < 14) begin
         send_word(OP_STY, word_t'($urandom_range(3)));
         send_word(($urandom_range(1) ? OP_DMY : OP_DPY), 0);
      end else if (r < 16) begin
         send_word(KIND_WIDTH'($urandom_range(127, 74)), rand_data());
      end else begin
         k = KIND_WIDTH'($urandom_range(73));
         send_word(k, rand_data());
      end
   endtask

   initial begin
      logic [KIND_WIDTH-1:0] op;
      sb = new();
      sb.clear();
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      write_csr(CSR_RAM_ID, 8'd0);
      write_csr(CSR_CPU_ID, 8'd255);
      // directed: edges, zero divisor, overflow divide, selector match
      send_word(OP_STX, MOST_NEG);
      send_word(OP_DIX, 0);
      send_word(OP_MOX, 0);
      send_word(OP_STY, -1);
      send_word(OP_TVY, 0);
      send_word(OP_DIX, 0);
      send_word(OP_STX, MOST_NEG);
      send_word(OP_MOX, 0);
      send_word(OP_STX, -7);
      send_word(OP_STY, 2);
      send_word(OP_TVY, 0);
      send_word(OP_DIY, 0);
      send_word(OP_MOX, 0);
      send_word(OP_RSX, 0);
      send_word(OP_RDM, {DATA_WIDTH{1'b1}});
      send_word(OP_TVF, 0);
      send_word(OP_LSX, 0);
      send_word(OP_MVX, 0);
      send_word(OP_LOG, 0);
      send_word(OP_IDN, 0);
      send_word(OP_CNE, 0);
      send_word(OP_TMX, 0);
      send_word(OP_TMY, 0);
      send_word(OP_END, 0);
      send_word(7'd127, 0);
      for (int i = 0; i < 74; i++) begin
         op = KIND_WIDTH'(i);
         send_word(op, rand_data());
      end
      drain();

      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0; stall_pct = 0; end
            1: begin send_idle_pct = 53; stall_pct = 0; end
            2: begin send_idle_pct = 0; stall_pct = 53; end
            3: begin send_idle_pct = 20; stall_pct = 20; end
            default: begin send_idle_pct = 0; stall_pct = 0; end
         endcase
         write_csr(CSR_RAM_ID, (phase == 4) ? 8'd255 : 8'($urandom_range(3)));
         write_csr(CSR_CPU_ID, (phase == 0) ? 8'd0 : 8'($urandom));
         if (phase == 4) hold_cycles = 300;
         for (int i = 0; i < 250; i++) begin
            send_random();
            // pause until everything has come back
            if (phase == 1 && i == 125) begin
               req_valid <= 0;
               while (sb.pending.size() > 0) @(posedge clock);
            end
         end
         drain();
      end

      if (error_count == 0 && sb.pending.size() == 0) begin
         $display("two_register_machine_execute test passed");
      end else begin
         $display("two_register_machine_execute test failed");
      end
      $finish;
   end
endmodule
`default_nettype wire
